// File: hdl/lcdws_pkg.sv
// shared types and constants for the 4-bit character lcd write sequencer
// item structs, item classes, register map, command bytes and reset values
// depends on nothing
`timescale 1ns / 1ps

package lcdws_pkg;

  // default microsecond ticks per millisecond
  localparam int TicksPerMsDefault = 1000;

  // fifo between classifier and executor
  localparam int QueueDepth = 2;

  // config port
  localparam int AddrWidth = 5;
  localparam int DataWidth = 32;

  // operation codes on the input channel
  localparam logic [2:0] OpTick   = 3'd0;
  localparam logic [2:0] OpCmd    = 3'd1;
  localparam logic [2:0] OpData   = 3'd2;
  localparam logic [2:0] OpCursor = 3'd3;
  localparam logic [2:0] OpClear  = 3'd4;
  localparam logic [2:0] OpInit   = 3'd5;

  // register indexes (byte address / 4)
  localparam logic [2:0] RegEnableHigh = 3'd0;
  localparam logic [2:0] RegEnableLow  = 3'd1;
  localparam logic [2:0] RegPowerupMs  = 3'd2;
  localparam logic [2:0] RegInitStepMs = 3'd3;
  localparam logic [2:0] RegClearMs    = 3'd4;

  // register reset values
  localparam logic [9:0] EnableHighReset = 10'd50;
  localparam logic [9:0] EnableLowReset  = 10'd50;
  localparam logic [9:0] PowerupMsReset  = 10'd100;
  localparam logic [9:0] InitStepMsReset = 10'd45;
  localparam logic [6:0] ClearMsReset    = 7'd3;

  // lcd command bytes
  localparam logic [7:0] CmdClear       = 8'h01;
  localparam logic [7:0] CmdWake        = 8'h03;
  localparam logic [7:0] CmdFourBit     = 8'h02;
  localparam logic [7:0] CmdFunctionSet = 8'h28;
  localparam logic [7:0] CmdDisplayOn   = 8'h0C;
  localparam logic [7:0] CmdEntryMode   = 8'h06;

  // sequence step indexes
  localparam logic [3:0] StepNone      = 4'd0;
  localparam logic [3:0] StepFirstInit = 4'd1;
  localparam logic [3:0] StepLastInit  = 4'd14;
  localparam logic [3:0] StepClearWait = 4'd15;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic [1:0] row;
  } in_item_t;

  typedef struct packed {
    logic       register_select;
    logic       enable_pin;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [9:0] enable_high_us;
    logic [9:0] enable_low_us;
    logic [9:0] powerup_wait_ms;
    logic [9:0] init_step_wait_ms;
    logic [6:0] clear_wait_ms;
  } cfg_t;

  typedef enum logic [1:0] {
    KindNop,
    KindTick,
    KindByte,
    KindInit
  } kind_e;

  // classified item as it sits in the fifo
  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_val;
    logic       rs;
    logic [3:0] seq_idx;
  } entry_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      default: base = 8'hD4;
    endcase
    return base;
  endfunction

endpackage

// File: hdl/lcdws_regs.sv
// apb-style configuration registers of the lcd write sequencer
// holds the enable timing and wait lengths; depends on lcdws_pkg
`timescale 1ns / 1ps

module lcdws_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lcdws_pkg::AddrWidth-1:0]  paddr,
  input  logic [lcdws_pkg::DataWidth-1:0]  pwdata,
  output logic [lcdws_pkg::DataWidth-1:0]  prdata,
  output logic                             pready,
  output lcdws_pkg::cfg_t                  cfg_o
);
  import lcdws_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[AddrWidth-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegEnableHigh: cfg_d.enable_high_us    = pwdata[9:0];
        RegEnableLow:  cfg_d.enable_low_us     = pwdata[9:0];
        RegPowerupMs:  cfg_d.powerup_wait_ms   = pwdata[9:0];
        RegInitStepMs: cfg_d.init_step_wait_ms = pwdata[9:0];
        RegClearMs:    cfg_d.clear_wait_ms     = pwdata[6:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegEnableHigh: prdata = DataWidth'(cfg_q.enable_high_us);
      RegEnableLow:  prdata = DataWidth'(cfg_q.enable_low_us);
      RegPowerupMs:  prdata = DataWidth'(cfg_q.powerup_wait_ms);
      RegInitStepMs: prdata = DataWidth'(cfg_q.init_step_wait_ms);
      RegClearMs:    prdata = DataWidth'(cfg_q.clear_wait_ms);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_high_us    <= EnableHighReset;
      cfg_q.enable_low_us     <= EnableLowReset;
      cfg_q.powerup_wait_ms   <= PowerupMsReset;
      cfg_q.init_step_wait_ms <= InitStepMsReset;
      cfg_q.clear_wait_ms     <= ClearMsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/lcdws_front.sv
// input side of the lcd write sequencer: takes items and classifies them
// resolves the byte to send, its rs level and the follow-up step; depends on lcdws_pkg
`timescale 1ns / 1ps

module lcdws_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcdws_pkg::in_item_t in_data_i,
  input  logic                full_i,
  output logic                push_o,
  output lcdws_pkg::entry_t   entry_o
);
  import lcdws_pkg::*;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  always_comb begin
    entry_o.kind     = KindNop;
    entry_o.byte_val = in_data_i.byte_value;
    entry_o.rs       = 1'b0;
    entry_o.seq_idx  = StepNone;
    case (in_data_i.operation)
      OpTick: entry_o.kind = KindTick;
      OpCmd:  entry_o.kind = KindByte;
      OpData: begin
        entry_o.kind = KindByte;
        entry_o.rs   = 1'b1;
      end
      OpCursor: begin
        // set ddram address, wraps to 8 bits
        entry_o.kind     = KindByte;
        entry_o.byte_val = row_base(in_data_i.row) + {2'b00, in_data_i.column};
      end
      OpClear: begin
        entry_o.kind     = KindByte;
        entry_o.byte_val = CmdClear;
        entry_o.seq_idx  = StepClearWait;
      end
      OpInit:  entry_o.kind = KindInit;
      default: entry_o.kind = KindNop;
    endcase
  end

endmodule

// File: hdl/lcdws_queue.sv
// small fifo between the classifier and the executor of the lcd write sequencer
// register-based storage with count; depends on lcdws_pkg
`timescale 1ns / 1ps

module lcdws_queue #(
  parameter int Depth = lcdws_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lcdws_pkg::entry_t entry_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output lcdws_pkg::entry_t entry_o
);
  import lcdws_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == DepthCnt);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt) else $error("queue count beyond depth");
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("pop from empty queue");
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != DepthCnt) else $error("push into full queue");

endmodule

// File: hdl/lcdws_back.sv
// executor of the lcd write sequencer: pin state, nibble timing and init/clear steps
// one queued item per cycle while the result beat is not stalled, into a registered result beat; depends on lcdws_pkg
`timescale 1ns / 1ps

module lcdws_back #(
  parameter int TicksPerMs = lcdws_pkg::TicksPerMsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcdws_pkg::cfg_t      cfg_i,
  input  logic                 q_valid_i,
  input  lcdws_pkg::entry_t    entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lcdws_pkg::out_item_t out_data_o
);
  import lcdws_pkg::*;

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhEnHigh = 2'd1;
  localparam logic [1:0] PhEnLow  = 2'd2;
  localparam logic [1:0] PhWait   = 2'd3;

  localparam logic [1:0] AdvIdle = 2'd0;
  localparam logic [1:0] AdvCmd  = 2'd1;
  localparam logic [1:0] AdvWait = 2'd2;

  typedef struct packed {
    logic       is_wait;
    logic [9:0] wait_ms;
    logic [7:0] cmd;
  } step_t;

  function automatic step_t decode_step(input logic [3:0] idx, input cfg_t cfg);
    step_t s;
    s.is_wait = 1'b1;
    s.wait_ms = '0;
    s.cmd     = '0;
    case (idx)
      4'd1, 4'd9, StepLastInit: s.wait_ms = cfg.powerup_wait_ms;
      4'd3, 4'd5, 4'd7:         s.wait_ms = cfg.init_step_wait_ms;
      StepClearWait:            s.wait_ms = {3'b000, cfg.clear_wait_ms};
      4'd2, 4'd4, 4'd6: begin
        s.is_wait = 1'b0;
        s.cmd     = CmdWake;
      end
      4'd8: begin
        s.is_wait = 1'b0;
        s.cmd     = CmdFourBit;
      end
      4'd10: begin
        s.is_wait = 1'b0;
        s.cmd     = CmdFunctionSet;
      end
      4'd11: begin
        s.is_wait = 1'b0;
        s.cmd     = CmdDisplayOn;
      end
      4'd12: begin
        s.is_wait = 1'b0;
        s.cmd     = CmdEntryMode;
      end
      default: begin
        s.is_wait = 1'b0;
        s.cmd     = CmdClear;
      end
    endcase
    return s;
  endfunction

  function automatic logic [3:0] next_step(input logic [3:0] idx);
    return (idx >= StepLastInit) ? StepNone : idx + 4'd1;
  endfunction

  // pin and sequencing state
  logic [1:0]  phase_q, phase_d;
  logic [19:0] time_left_q, time_left_d;
  logic [7:0]  byte_hold_q, byte_hold_d;
  logic        low_next_q, low_next_d;
  logic        rs_q, rs_d;
  logic        en_q, en_d;
  logic [3:0]  nibble_q, nibble_d;
  logic [3:0]  init_idx_q, init_idx_d;

  // result register
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        fire;
  logic        busy;
  logic        rej;
  logic [19:0] en_high_t, en_low_t;

  // sequence advance
  logic        use_adv;
  logic [3:0]  sel_idx, nxt1, adv_next;
  step_t       step1, step2;
  logic [1:0]  adv_kind;
  logic [7:0]  adv_cmd;
  logic [19:0] adv_time;

  // byte start
  logic        bb_go;
  logic [7:0]  bb_byte;
  logic        bb_rs;

  assign busy      = (phase_q != PhIdle);
  assign fire      = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o     = fire;
  assign en_high_t = (cfg_i.enable_high_us == '0) ? 20'd1 : 20'(cfg_i.enable_high_us);
  assign en_low_t  = (cfg_i.enable_low_us == '0) ? 20'd1 : 20'(cfg_i.enable_low_us);

  // next sequence step; a zero wait falls through to the command after it,
  // and a wait is always followed by a command or the end of the sequence
  assign sel_idx = (entry_i.kind == KindInit) ? StepFirstInit : init_idx_q;
  assign step1   = decode_step(sel_idx, cfg_i);
  assign nxt1    = next_step(sel_idx);
  assign step2   = decode_step(nxt1, cfg_i);

  always_comb begin
    adv_kind = AdvIdle;
    adv_cmd  = step1.cmd;
    adv_time = 20'(32'(step1.wait_ms) * 32'(TicksPerMs));
    adv_next = nxt1;
    if (sel_idx == StepNone) begin
      adv_next = StepNone;
    end else if (!step1.is_wait) begin
      adv_kind = AdvCmd;
    end else if (step1.wait_ms != '0) begin
      adv_kind = AdvWait;
    end else if (nxt1 == StepNone) begin
      adv_next = StepNone;
    end else begin
      adv_next = next_step(nxt1);
      if (!step2.is_wait) begin
        adv_kind = AdvCmd;
        adv_cmd  = step2.cmd;
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    time_left_d = time_left_q;
    byte_hold_d = byte_hold_q;
    low_next_d  = low_next_q;
    rs_d        = rs_q;
    en_d        = en_q;
    nibble_d    = nibble_q;
    init_idx_d  = init_idx_q;
    rej         = 1'b0;
    use_adv     = 1'b0;
    bb_go       = 1'b0;
    bb_byte     = entry_i.byte_val;
    bb_rs       = entry_i.rs;

    if (fire) begin
      case (entry_i.kind)
        KindTick: begin
          if (busy) begin
            if (time_left_q > 20'd1) begin
              time_left_d = time_left_q - 20'd1;
            end else begin
              time_left_d = '0;
              if (phase_q == PhEnHigh) begin
                en_d        = 1'b0;
                phase_d     = PhEnLow;
                time_left_d = en_low_t;
              end else if (phase_q == PhEnLow && low_next_q) begin
                // second nibble of the byte
                low_next_d  = 1'b0;
                nibble_d    = byte_hold_q[3:0];
                en_d        = 1'b1;
                phase_d     = PhEnHigh;
                time_left_d = en_high_t;
              end else begin
                use_adv = 1'b1;
              end
            end
          end
        end
        KindByte: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            init_idx_d = entry_i.seq_idx;
            bb_go      = 1'b1;
          end
        end
        KindInit: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            use_adv = 1'b1;
          end
        end
        default: begin
          rej = 1'b0;
        end
      endcase

      if (use_adv) begin
        init_idx_d = adv_next;
        case (adv_kind)
          AdvCmd: begin
            bb_go   = 1'b1;
            bb_byte = adv_cmd;
            bb_rs   = 1'b0;
          end
          AdvWait: begin
            phase_d     = PhWait;
            time_left_d = adv_time;
          end
          default: begin
            phase_d     = PhIdle;
            time_left_d = '0;
          end
        endcase
      end

      if (bb_go) begin
        // high nibble first
        byte_hold_d = bb_byte;
        rs_d        = bb_rs;
        low_next_d  = 1'b1;
        nibble_d    = bb_byte[7:4];
        en_d        = 1'b1;
        phase_d     = PhEnHigh;
        time_left_d = en_high_t;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    if (fire) begin
      out_valid_d           = 1'b1;
      out_d.register_select = rs_d;
      out_d.enable_pin      = en_d;
      out_d.data_nibble     = nibble_d;
      out_d.busy_res        = (phase_d != PhIdle);
      out_d.rejected        = rej;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      time_left_q <= '0;
      byte_hold_q <= '0;
      low_next_q  <= 1'b0;
      rs_q        <= 1'b0;
      en_q        <= 1'b0;
      nibble_q    <= '0;
      init_idx_q  <= StepNone;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      time_left_q <= time_left_d;
      byte_hold_q <= byte_hold_d;
      low_next_q  <= low_next_d;
      rs_q        <= rs_d;
      en_q        <= en_d;
      nibble_q    <= nibble_d;
      init_idx_q  <= init_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_en_in_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_q |-> phase_q == PhEnHigh) else $error("enable high outside enable phase");
  a_idle_no_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> time_left_q == '0) else $error("idle with time left");
  a_busy_has_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhIdle |-> time_left_q != '0) else $error("busy phase with no time");
  a_rej_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rejected |-> out_q.busy_res) else $error("reject while idle");

endmodule

// File: hdl/char_lcd_4bit_write_sequencer_unit.sv
// top level of the 4-bit character lcd write sequencer
// ties config registers, classifier, fifo and executor; depends on lcdws_pkg
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   in_data_i  (operation, byte, column, row)
// out       output     out_valid_o / out_stall_i out_data_o (rs, e, d7..d4, busy, rejected)
// config    input      psel/penable/pwrite/pready paddr, pwdata, prdata (5 regs at 4*i)
//
// one item per clock sustained while the result is not stalled; each item gives one
// result beat (fifo write, then executor into the result register)
// the rate is set by the executor, which applies one item's state update per cycle
// reset is asynchronous and active low; no clearing pass, the block takes items
// in the first cycle after reset
// a stalled result holds the executor; the two-entry fifo keeps the input open
// until it fills, and in_stall_o rises while the fifo is full

module char_lcd_4bit_write_sequencer_unit #(
  parameter int TicksPerMs = lcdws_pkg::TicksPerMsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lcdws_pkg::in_item_t              in_data_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lcdws_pkg::out_item_t             out_data_o,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lcdws_pkg::AddrWidth-1:0]  paddr,
  input  logic [lcdws_pkg::DataWidth-1:0]  pwdata,
  output logic [lcdws_pkg::DataWidth-1:0]  prdata,
  output logic                             pready
);
  import lcdws_pkg::*;

  cfg_t   cfg;
  entry_t push_entry, head_entry;
  logic   push, pop, q_valid, q_full;

  // timing and wait registers
  lcdws_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // classify op into tick / byte / init / ignored
  lcdws_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // decouples intake from result backpressure
  lcdws_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .entry_o (head_entry)
  );

  // pin state machine, nibble timing, init and clear steps
  lcdws_back #(
    .TicksPerMs (TicksPerMs)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: bench/char_lcd_4bit_write_sequencer_unit_tb.sv
// self-checking bench for the 4-bit character lcd write sequencer
// a clocked driver and monitor around an in-bench pin-level predictor;
// depends on lcdws_pkg and char_lcd_4bit_write_sequencer_unit
`timescale 1ns / 1ps

module char_lcd_4bit_write_sequencer_unit_tb;
  import lcdws_pkg::*;

  localparam int LcdTicksPerMs = TicksPerMsDefault;
  // cycles without any beat before the run is called hung
  localparam int QuietLimit = 1000;
  // cycles to wait after the last result
  localparam int SettleCycles = 10;

  // operation codes the block ignores
  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;

  // lcd command bytes as the display expects them
  localparam logic [7:0] LcdClear   = 8'h01;
  localparam logic [7:0] LcdWake    = 8'h03;
  localparam logic [7:0] LcdFourBit = 8'h02;
  localparam logic [7:0] LcdFuncSet = 8'h28;
  localparam logic [7:0] LcdDispOn  = 8'h0C;
  localparam logic [7:0] LcdEntry   = 8'h06;

  // ddram base address per row, row 0 in the low byte
  localparam logic [31:0] RowBases = 32'hD4_94_C0_80;

  // init script steps; 0 means no script, 15 is the wait after a clear
  localparam logic [3:0] SeqNone     = 4'd0;
  localparam logic [3:0] SeqPowerupA = 4'd1;
  localparam logic [3:0] SeqWakeA    = 4'd2;
  localparam logic [3:0] SeqSettleA  = 4'd3;
  localparam logic [3:0] SeqWakeB    = 4'd4;
  localparam logic [3:0] SeqSettleB  = 4'd5;
  localparam logic [3:0] SeqWakeC    = 4'd6;
  localparam logic [3:0] SeqSettleC  = 4'd7;
  localparam logic [3:0] SeqFourBit  = 4'd8;
  localparam logic [3:0] SeqPowerupB = 4'd9;
  localparam logic [3:0] SeqFuncSet  = 4'd10;
  localparam logic [3:0] SeqDispOn   = 4'd11;
  localparam logic [3:0] SeqEntry    = 4'd12;
  localparam logic [3:0] SeqClear    = 4'd13;
  localparam logic [3:0] SeqPowerupC = 4'd14;
  localparam logic [3:0] SeqClearGap = 4'd15;

  typedef enum logic [1:0] {
    LcdIdle,
    LcdEnHigh,
    LcdEnLow,
    LcdWait
  } lcd_phase_e;

  // predicted sequencer state
  typedef struct packed {
    lcd_phase_e ph;
    logic [19:0] left;      // ticks left in the current phase
    logic [7:0]  hold;      // byte on its way out
    logic        low_next;  // low nibble still to go
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [3:0]  step;      // next script step
  } lcd_state_t;

  typedef struct packed {
    lcd_state_t st;
    out_item_t  res;
  } lcd_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_item_t out_data_o;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  char_lcd_4bit_write_sequencer_unit #(
    .TicksPerMs(LcdTicksPerMs)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register copy shared by the predictor and the stimulus planner;
  // only changed while nothing is in flight
  cfg_t lcd_cfg;

  lcd_state_t lcd_model = '0;   // follows accepted input beats
  lcd_state_t lcd_plan = '0;    // follows queued items, used to shape stimulus
  lcd_step_t  drv_step;
  out_item_t  want;

  in_item_t  lcd_pending[$];
  out_item_t lcd_expected[$];

  int src_idle_pct = 27;
  int sink_stall_pct = 71;
  int mismatches = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // pin-level predictor
  // ---------------------------------------------------------------------------

  // raise enable with a new nibble; a zero enable time still lasts one tick
  function automatic lcd_state_t nibble_start(input lcd_state_t s, input cfg_t c,
                                              input logic [3:0] nib);
    s.nib = nib;
    s.en = 1'b1;
    s.ph = LcdEnHigh;
    s.left = (c.enable_high_us == '0) ? 20'd1 : 20'(c.enable_high_us);
    return s;
  endfunction

  // a byte leaves high nibble first
  function automatic lcd_state_t byte_start(input lcd_state_t s, input cfg_t c,
                                            input logic [7:0] b, input logic rs);
    s.hold = b;
    s.rs = rs;
    s.low_next = 1'b1;
    return nibble_start(s, c, b[7:4]);
  endfunction

  // walk the script until a byte starts, a nonzero wait begins or the script ends
  function automatic lcd_state_t sequence_next(input lcd_state_t s, input cfg_t c);
    logic [3:0]  cur;
    logic [9:0]  ms;
    logic [7:0]  cmd;
    logic        is_wait;
    logic [31:0] prod;
    repeat (16) begin
      if (s.step == SeqNone) begin
        s.ph = LcdIdle;
        s.left = '0;
        return s;
      end
      cur = s.step;
      s.step = (cur >= SeqPowerupC) ? SeqNone : cur + 4'd1;
      ms = '0;
      cmd = '0;
      is_wait = 1'b1;
      case (cur)
        SeqPowerupA, SeqPowerupB, SeqPowerupC: ms = c.powerup_wait_ms;
        SeqSettleA, SeqSettleB, SeqSettleC:    ms = c.init_step_wait_ms;
        SeqClearGap:                           ms = 10'(c.clear_wait_ms);
        SeqWakeA, SeqWakeB, SeqWakeC: begin
          cmd = LcdWake;
          is_wait = 1'b0;
        end
        SeqFourBit: begin
          cmd = LcdFourBit;
          is_wait = 1'b0;
        end
        SeqFuncSet: begin
          cmd = LcdFuncSet;
          is_wait = 1'b0;
        end
        SeqDispOn: begin
          cmd = LcdDispOn;
          is_wait = 1'b0;
        end
        SeqEntry: begin
          cmd = LcdEntry;
          is_wait = 1'b0;
        end
        default: begin
          cmd = LcdClear;
          is_wait = 1'b0;
        end
      endcase
      if (!is_wait) begin
        return byte_start(s, c, cmd, 1'b0);
      end
      // a zero-length wait falls straight through to the next step
      if (ms != '0) begin
        prod = 32'(ms) * LcdTicksPerMs;
        s.ph = LcdWait;
        s.left = prod[19:0];
        if (s.left != '0) begin
          return s;
        end
      end
    end
    return s;
  endfunction

  // one item in, next state and pin levels out
  function automatic lcd_step_t lcd_apply(input lcd_state_t s, input cfg_t c,
                                          input in_item_t it);
    lcd_step_t  r;
    logic [7:0] addr;
    r.res.rejected = 1'b0;
    // cursor address wraps to 8 bits
    addr = RowBases[{it.row, 3'b000} +: 8] + {2'b00, it.column};
    case (it.operation)
      OpTick: begin
        // a tick only moves time while something is running
        if (s.ph != LcdIdle) begin
          if (s.left > 20'd1) begin
            s.left = s.left - 20'd1;
          end else begin
            s.left = '0;
            if (s.ph == LcdEnHigh) begin
              s.en = 1'b0;
              s.ph = LcdEnLow;
              s.left = (c.enable_low_us == '0) ? 20'd1 : 20'(c.enable_low_us);
            end else if (s.ph == LcdEnLow && s.low_next) begin
              s.low_next = 1'b0;
              s = nibble_start(s, c, s.hold[3:0]);
            end else begin
              s = sequence_next(s, c);
            end
          end
        end
      end
      OpCmd, OpData, OpCursor, OpClear, OpInit: begin
        if (s.ph != LcdIdle) begin
          // dropped while busy, nothing else moves
          r.res.rejected = 1'b1;
        end else begin
          case (it.operation)
            OpCmd: begin
              s.step = SeqNone;
              s = byte_start(s, c, it.byte_value, 1'b0);
            end
            OpData: begin
              s.step = SeqNone;
              s = byte_start(s, c, it.byte_value, 1'b1);
            end
            OpCursor: begin
              s.step = SeqNone;
              s = byte_start(s, c, addr, 1'b0);
            end
            OpClear: begin
              s.step = SeqClearGap;
              s = byte_start(s, c, LcdClear, 1'b0);
            end
            default: begin
              s.step = SeqPowerupA;
              s = sequence_next(s, c);
            end
          endcase
        end
      end
      default: ;  // spare codes leave everything alone
    endcase
    r.st = s;
    r.res.register_select = s.rs;
    r.res.enable_pin = s.en;
    r.res.data_nibble = s.nib;
    r.res.busy_res = (s.ph != LcdIdle);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: one beat at a time from the pending queue
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        drv_step = lcd_apply(lcd_model, lcd_cfg, in_data);
        lcd_model = drv_step.st;
        lcd_expected.push_back(drv_step.res);
        void'(lcd_pending.pop_front());
      end
      // a stalled beat holds; otherwise offer the next item or idle
      if (!(in_valid && in_stall_o)) begin
        if (lcd_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= lcd_pending[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: each beat against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [3:0] exp_v,
                             input logic [3:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (lcd_expected.size() == 0) begin
          $error("result beat with no prediction waiting");
          mismatches++;
        end else begin
          want = lcd_expected.pop_front();
          check_field("register_select", want.register_select, out_data_o.register_select);
          check_field("enable_pin", want.enable_pin, out_data_o.enable_pin);
          check_field("data_nibble", want.data_nibble, out_data_o.data_nibble);
          check_field("busy_res", want.busy_res, out_data_o.busy_res);
          check_field("rejected", want.rejected, out_data_o.rejected);
        end
      end
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // hang detector: no beat on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_item(input logic [2:0] op, input logic [7:0] b,
                                       input logic [5:0] col, input logic [1:0] row);
    in_item_t it;
    it.operation = op;
    it.byte_value = b;
    it.column = col;
    it.row = row;
    return it;
  endfunction

  // busy: mostly ticks with a few refused requests; idle: mostly new requests
  function automatic in_item_t random_item(input logic busy);
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(99);
    if (busy) begin
      if (pick < 85)      op = OpTick;
      else if (pick < 95) op = 3'($urandom_range(OpInit, OpCmd));
      else                op = 3'($urandom_range(OpSpareHi, OpSpareLo));
    end else begin
      if (pick < 4)       op = OpTick;
      else if (pick < 8)  op = 3'($urandom_range(OpSpareHi, OpSpareLo));
      else if (pick < 30) op = OpCmd;
      else if (pick < 55) op = OpData;
      else if (pick < 78) op = OpCursor;
      else if (pick < 90) op = OpClear;
      else                op = OpInit;
    end
    return mk_item(op, 8'($urandom), 6'($urandom), 2'($urandom));
  endfunction

  task automatic queue_item(input in_item_t it);
    lcd_step_t nxt;
    nxt = lcd_apply(lcd_plan, lcd_cfg, it);
    lcd_plan = nxt.st;
    lcd_pending.push_back(it);
  endtask

  // tick until the planned sequencer has gone idle
  task automatic drain_plan();
    while (lcd_plan.ph != LcdIdle) begin
      queue_item(mk_item(OpTick, 8'($urandom), 6'($urandom), 2'($urandom)));
    end
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [DataWidth-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // new register setting and traffic shape; called only with nothing in flight
  task automatic apply_setting(input int high_us, input int low_us, input int pwr_ms,
                               input int step_ms, input int clr_ms,
                               input int src_pct, input int sink_pct);
    cfg_t c;
    c.enable_high_us = 10'(high_us);
    c.enable_low_us = 10'(low_us);
    c.powerup_wait_ms = 10'(pwr_ms);
    c.init_step_wait_ms = 10'(step_ms);
    c.clear_wait_ms = 7'(clr_ms);
    reg_write(RegEnableHigh, DataWidth'(c.enable_high_us));
    reg_write(RegEnableLow, DataWidth'(c.enable_low_us));
    reg_write(RegPowerupMs, DataWidth'(c.powerup_wait_ms));
    reg_write(RegInitStepMs, DataWidth'(c.init_step_wait_ms));
    reg_write(RegClearMs, DataWidth'(c.clear_wait_ms));
    lcd_cfg = c;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // a leading request, random items, ticks until idle, then wait for all results
  task automatic run_items(input in_item_t lead, input int budget);
    queue_item(lead);
    repeat (budget) queue_item(random_item(lcd_plan.ph != LcdIdle));
    drain_plan();
    while (lcd_pending.size() != 0 || lcd_expected.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    lcd_cfg.enable_high_us = EnableHighReset;
    lcd_cfg.enable_low_us = EnableLowReset;
    lcd_cfg.powerup_wait_ms = PowerupMsReset;
    lcd_cfg.init_step_wait_ms = InitStepMsReset;
    lcd_cfg.clear_wait_ms = ClearMsReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: a data byte and three random items at 50/50 us enable timing
    run_items(mk_item(OpData, 8'hA5, 6'h2A, 2'd1), 3);

    // directed part with one-tick enable phases and no waits
    apply_setting(0, 0, 0, 0, 0, 27, 71);
    queue_item(mk_item(OpTick, 8'h00, 6'h00, 2'd0));      // tick while idle
    queue_item(mk_item(OpSpareLo, 8'hFF, 6'h3F, 2'd3));   // ignored codes
    queue_item(mk_item(OpSpareHi, 8'h00, 6'h00, 2'd0));
    queue_item(mk_item(OpCmd, 8'hFF, 6'h3F, 2'd3));
    queue_item(mk_item(OpClear, 8'h00, 6'h00, 2'd0));     // refused, still busy
    drain_plan();
    queue_item(mk_item(OpData, 8'h00, 6'h00, 2'd0));
    drain_plan();
    queue_item(mk_item(OpCursor, 8'h5A, 6'h3F, 2'd3));    // 0xd4 + 63 wraps
    drain_plan();
    queue_item(mk_item(OpClear, 8'hFF, 6'h15, 2'd2));     // clear with no wait after
    drain_plan();
    run_items(mk_item(OpInit, 8'h33, 6'h2A, 2'd1), 80);   // init with every wait skipped

    // sender seldom idle, receiver stalling often
    apply_setting(1, 1, 0, 0, 0, 27, 71);
    run_items(mk_item(OpCmd, 8'h80, 6'h01, 2'd2), 110);

    // roles swapped: sender idles often, receiver rarely stalls;
    // one millisecond is a thousand ticks, so waits stay at zero here
    apply_setting(3, 2, 0, 0, 0, 71, 27);
    run_items(mk_item(OpInit, 8'h0F, 6'h10, 2'd0), 80);
    apply_setting(1, 2, 0, 0, 0, 71, 27);
    run_items(mk_item(OpCursor, 8'hF0, 6'h20, 2'd3), 80);
    apply_setting(7, 5, 0, 0, 0, 71, 27);
    run_items(mk_item(OpClear, 8'h3C, 6'h05, 2'd1), 80);

    // no idling on either side
    apply_setting(1, 0, 0, 0, 0, 0, 0);
    run_items(mk_item(OpCursor, 8'hC3, 6'h00, 2'd0), 60);
    apply_setting(0, 1, 0, 0, 0, 0, 0);
    run_items(mk_item(OpData, 8'h7E, 6'h3E, 2'd1), 60);

    // large register values last: init enters a wait of a million ticks,
    // a few ticks and refused requests follow and the run ends inside the wait
    apply_setting(1000, 1000, 1000, 1000, 100, 0, 0);
    queue_item(mk_item(OpInit, 8'h99, 6'h33, 2'd2));
    repeat (30) queue_item(random_item(lcd_plan.ph != LcdIdle));
    while (lcd_pending.size() != 0 || lcd_expected.size() != 0) @(posedge clk_i);

    // let any stray result beat show up before the verdict
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lcdws_pkg.sv
hdl/lcdws_regs.sv
hdl/lcdws_front.sv
hdl/lcdws_queue.sv
hdl/lcdws_back.sv
hdl/char_lcd_4bit_write_sequencer_unit.sv
bench/char_lcd_4bit_write_sequencer_unit_tb.sv
